/* rtl/mrp_pkg.sv */
// Shared types, codes and constants for the MIPS REL relocation patcher.
`default_nettype none

package mrp_pkg;

	// Depth of the pending HI16 stack and the widths that follow from it.
	localparam int PEND_DEPTH = 63;
	localparam int CNT_W      = 6;
	localparam int IDX_W      = 6;

	// Relocation types carried in the opcode field.
	localparam logic [2:0] OP_NONE   = 3'd0;
	localparam logic [2:0] OP_ABS16  = 3'd1;
	localparam logic [2:0] OP_ABS32  = 3'd2;
	localparam logic [2:0] OP_JUMP26 = 3'd3;
	localparam logic [2:0] OP_HI16   = 3'd4;
	localparam logic [2:0] OP_LO16   = 3'd5;
	localparam logic [2:0] OP_PC16   = 3'd6;
	localparam logic [2:0] OP_UNSUP  = 3'd7;

	// Status codes of a result beat.
	localparam logic [2:0] ST_OK       = 3'd0;
	localparam logic [2:0] ST_OVERFLOW = 3'd1;
	localparam logic [2:0] ST_UNSUP    = 3'd2;
	localparam logic [2:0] ST_FULL     = 3'd3;
	localparam logic [2:0] ST_ZERO_SYM = 3'd4;

	// Operand selections of the shared adder.
	localparam logic [2:0] SEL_SYM_SEXT16 = 3'd0;
	localparam logic [2:0] SEL_SYM_WORD   = 3'd1;
	localparam logic [2:0] SEL_JUMP_LOCAL = 3'd2;
	localparam logic [2:0] SEL_JUMP_EXT   = 3'd3;
	localparam logic [2:0] SEL_PC_FIRST   = 3'd4;
	localparam logic [2:0] SEL_PC_SECOND  = 3'd5;
	localparam logic [2:0] SEL_HI_ADJUST  = 3'd6;

	// Field masks.
	localparam logic [31:0] IDX_MASK = 32'h03ff_ffff;
	localparam logic [31:0] SEG_MASK = 32'hf000_0000;
	localparam logic [31:0] J_SIGN   = 32'h0800_0000;
	localparam logic [31:0] HI_MASK  = 32'hffff_0000;

	typedef struct packed {
		logic [2:0]  opcode;
		logic [31:0] target_address;
		logic [31:0] current_word;
		logic [31:0] symbol_value;
		logic        is_section_symbol;
	} in_item_t;

	typedef struct packed {
		logic [31:0] write_address;
		logic [31:0] write_data;
		logic        write_enable;
		logic [2:0]  status;
		logic        last;
	} out_item_t;

	// One pending HI16 entry: its address and the word as it was pushed.
	typedef struct packed {
		logic [31:0] addr;
		logic [31:0] word;
	} pend_entry_t;

	// Stack commands from the sequencer.
	typedef struct packed {
		logic push;
		logic pop;
	} stk_ctl_t;

	// Stack status back to the sequencer.
	typedef struct packed {
		logic full;
		logic empty;
	} stk_sts_t;

	function automatic logic [31:0] sext16(input logic [15:0] v);
		sext16 = {{16{v[15]}}, v};
	endfunction

endpackage

`default_nettype wire

/* rtl/mips_rel_relocation_patcher.sv */
// Top level of the MIPS REL relocation patcher: sequencer and result register.
//
//   channel | direction | handshake          | payload
//   req     | in        | req_valid/req_stall | mrp_pkg::in_item_t
//   rsp     | out       | rsp_valid/rsp_stall | mrp_pkg::out_item_t
//
// One relocation steps through accept, add and result; PC16 adds a second add step since
// its two additions share the one adder. A LO16 that drains the pending stack adds, per
// popped HI16 entry, a step for the stack memory read and a step for the adder.
// Reset clears the sequencer, the result valid and the fill count; no clearing pass.
// A stalled result holds the sequencer in place; req_stall is high while an item is
// being worked on.
`default_nettype none

module mips_rel_relocation_patcher (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                req_valid,
	output logic                     req_stall,
	input  wire mrp_pkg::in_item_t   req,
	output logic                     rsp_valid,
	input  wire logic                rsp_stall,
	output mrp_pkg::out_item_t       rsp
);
	import mrp_pkg::*;

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_CALC  = 3'd1;
	localparam logic [2:0] S_CALC2 = 3'd2;
	localparam logic [2:0] S_FORM  = 3'd3;
	localparam logic [2:0] S_RD    = 3'd4;
	localparam logic [2:0] S_POP   = 3'd5;

	logic [2:0]  state_q;
	logic [2:0]  state_d;
	in_item_t    item_q;
	logic [31:0] acc_q;
	logic        out_valid_q;
	out_item_t   out_q;

	logic        [2:0]  alu_sel;
	logic        [31:0] alu_sum;
	stk_ctl_t           stk_ctl;
	stk_sts_t           stk_sts;
	pend_entry_t        pend_wr;
	pend_entry_t        pend_rd;
	out_item_t          form;
	logic               out_free;
	logic               out_load;
	logic               accept;
	logic               drain;

	assign req_stall = (state_q != S_IDLE);
	assign accept    = req_valid && !req_stall;
	assign out_free  = !out_valid_q || !rsp_stall;
	assign drain     = (item_q.opcode == OP_LO16) && (item_q.symbol_value != 32'd0);

	// Adder operand selection per step.
	always_comb begin
		alu_sel = SEL_SYM_WORD;
		case (state_q)
			S_CALC: begin
				case (item_q.opcode)
					OP_ABS16, OP_LO16: alu_sel = SEL_SYM_SEXT16;
					OP_JUMP26: alu_sel = item_q.is_section_symbol ? SEL_JUMP_LOCAL
						: SEL_JUMP_EXT;
					OP_PC16:   alu_sel = SEL_PC_FIRST;
					default:   alu_sel = SEL_SYM_WORD;
				endcase
			end
			S_CALC2: alu_sel = SEL_PC_SECOND;
			S_POP:   alu_sel = SEL_HI_ADJUST;
			default: alu_sel = SEL_SYM_WORD;
		endcase
	end

	mrp_alu u_alu (
		.sel  (alu_sel),
		.item (item_q),
		.acc  (acc_q),
		.pend (pend_rd),
		.sum  (alu_sum)
	);

	assign pend_wr.addr = item_q.target_address;
	assign pend_wr.word = item_q.current_word;

	mrp_stack u_stack (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (stk_ctl),
		.wr_entry (pend_wr),
		.rd_entry (pend_rd),
		.sts      (stk_sts)
	);

	// Result of the item itself, formed from the accumulated sum.
	always_comb begin
		form.write_address = item_q.target_address;
		form.write_data    = item_q.current_word;
		form.write_enable  = 1'b0;
		form.status        = ST_OK;
		form.last          = 1'b1;
		case (item_q.opcode)
			OP_NONE: begin
				form.status = ST_OK;
			end
			OP_ABS16: begin
				if (acc_q[31:16] != 16'd0) begin
					form.status = ST_OVERFLOW;
				end else begin
					form.write_data   = {item_q.current_word[31:16], acc_q[15:0]};
					form.write_enable = 1'b1;
				end
			end
			OP_ABS32: begin
				form.write_data   = acc_q;
				form.write_enable = (acc_q != item_q.current_word);
			end
			OP_JUMP26: begin
				form.write_data   = {item_q.current_word[31:26], acc_q[27:2]};
				form.write_enable = 1'b1;
			end
			OP_HI16: begin
				form.status = stk_sts.full ? ST_FULL : ST_OK;
			end
			OP_LO16: begin
				if (item_q.symbol_value == 32'd0) begin
					form.status = ST_ZERO_SYM;
				end else begin
					form.write_data   = {item_q.current_word[31:16], acc_q[15:0]};
					form.write_enable = 1'b1;
					form.last         = stk_sts.empty;
				end
			end
			OP_PC16: begin
				// In range when bits 31 down to 17 of the difference all agree.
				if ((acc_q[31:17] != 15'd0) && (acc_q[31:17] != 15'h7fff)) begin
					form.status = ST_OVERFLOW;
				end else begin
					form.write_data   = {item_q.current_word[31:16], acc_q[17:2]};
					form.write_enable = 1'b1;
				end
			end
			default: begin
				form.status = ST_UNSUP;
			end
		endcase
	end

	// Sequencer next state and stack commands.
	always_comb begin
		state_d      = state_q;
		stk_ctl.push = 1'b0;
		stk_ctl.pop  = 1'b0;
		out_load     = 1'b0;
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					state_d = S_CALC;
				end
			end
			S_CALC: begin
				state_d = (item_q.opcode == OP_PC16) ? S_CALC2 : S_FORM;
			end
			S_CALC2: begin
				state_d = S_FORM;
			end
			S_FORM: begin
				if (out_free) begin
					out_load     = 1'b1;
					stk_ctl.push = (item_q.opcode == OP_HI16) && !stk_sts.full;
					state_d      = (drain && !stk_sts.empty) ? S_RD : S_IDLE;
				end
			end
			S_RD: begin
				stk_ctl.pop = 1'b1;
				state_d     = S_POP;
			end
			S_POP: begin
				if (out_free) begin
					out_load = 1'b1;
					state_d  = stk_sts.empty ? S_IDLE : S_RD;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Item, sum and result beat registers.
	always_ff @(posedge clk) begin
		if (accept) begin
			item_q <= req;
		end
		if (state_q == S_CALC || state_q == S_CALC2) begin
			acc_q <= alu_sum;
		end
		if (out_load) begin
			if (state_q == S_POP) begin
				out_q.write_address <= pend_rd.addr;
				out_q.write_data    <= {pend_rd.word[31:16], alu_sum[15:0]};
				out_q.write_enable  <= 1'b1;
				out_q.status        <= ST_OK;
				out_q.last          <= stk_sts.empty;
			end else begin
				out_q <= form;
			end
		end
	end

	assign rsp_valid = out_valid_q;
	assign rsp       = out_q;

endmodule

`default_nettype wire

/* rtl/mrp_alu.sv */
// Shared 32-bit adder with operand selection for every relocation step.
`default_nettype none

module mrp_alu (
	input  wire logic [2:0]          sel,
	input  wire mrp_pkg::in_item_t   item,
	input  wire logic [31:0]         acc,
	input  wire mrp_pkg::pend_entry_t pend,
	output logic [31:0]              sum
);
	import mrp_pkg::*;

	logic [31:0] op_a;
	logic [31:0] op_b;
	logic        cin;
	logic [31:0] jidx;

	// Jump index shifted into byte units.
	assign jidx = (item.current_word & IDX_MASK) << 2;

	// Operand selection.
	always_comb begin
		op_a = item.symbol_value;
		op_b = item.current_word;
		cin  = 1'b0;
		case (sel)
			SEL_SYM_SEXT16: begin
				op_b = sext16(item.current_word[15:0]);
			end
			SEL_SYM_WORD: begin
				op_b = item.current_word;
			end
			SEL_JUMP_LOCAL: begin
				op_b = (item.target_address & SEG_MASK) | jidx;
			end
			SEL_JUMP_EXT: begin
				op_b = ((jidx & J_SIGN) != 32'd0) ? (jidx | SEG_MASK) : jidx;
			end
			SEL_PC_FIRST: begin
				op_b = sext16(item.current_word[15:0]) << 2;
			end
			SEL_PC_SECOND: begin
				// Subtract the address from the first partial sum.
				op_a = acc;
				op_b = ~item.target_address;
				cin  = 1'b1;
			end
			SEL_HI_ADJUST: begin
				// High half plus the carry that the sign of the low half brings in.
				op_a = {16'd0, pend.word[15:0]};
				op_b = {16'd0, acc[31:16]};
				cin  = acc[15];
			end
			default: begin
				op_b = item.current_word;
			end
		endcase
	end

	assign sum = op_a + op_b + {31'd0, cin};

endmodule

`default_nettype wire

/* rtl/mrp_stack.sv */
// Pending HI16 stack: entry memory with registered read and the fill count.
`default_nettype none

module mrp_stack (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire mrp_pkg::stk_ctl_t    ctl,
	input  wire mrp_pkg::pend_entry_t wr_entry,
	output mrp_pkg::pend_entry_t      rd_entry,
	output mrp_pkg::stk_sts_t         sts
);
	import mrp_pkg::*;

	pend_entry_t      mem [PEND_DEPTH];
	pend_entry_t      rd_q;
	logic [CNT_W-1:0] count_q;
	logic [IDX_W-1:0] top_idx;

	assign top_idx = count_q[IDX_W-1:0] - IDX_W'(1);

	// Push writes at the fill count; pop reads the top entry.
	always_ff @(posedge clk) begin
		if (ctl.push) begin
			mem[count_q[IDX_W-1:0]] <= wr_entry;
		end
		if (ctl.pop) begin
			rd_q <= mem[top_idx];
		end
	end

	// Fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (ctl.push) begin
			count_q <= count_q + CNT_W'(1);
		end else if (ctl.pop) begin
			count_q <= count_q - CNT_W'(1);
		end
	end

	assign rd_entry  = rd_q;
	assign sts.empty = (count_q == '0);
	assign sts.full  = (count_q >= CNT_W'(PEND_DEPTH));

endmodule

`default_nettype wire

/* bench/tb_top.sv */
// Self-checking testbench for the MIPS REL relocation patcher with a built-in patch predictor.
`timescale 1ns / 1ps

module tb_top;
	import mrp_pkg::*;

	localparam int QUIET_LIMIT = 3000;
	localparam int HOLD_CYCLES = 150;
	localparam int HOLD_AFTER  = 40;

	logic      clk;
	logic      arst_n    = 1'b0;
	logic      req_valid = 1'b0;
	logic      req_stall;
	in_item_t  req       = '0;
	logic      rsp_valid;
	logic      rsp_stall = 1'b0;
	out_item_t rsp;

	// Relocations waiting to be offered, and the write beats the predictor expects back.
	in_item_t  relocs_todo[$];
	out_item_t expected_writes[$];

	// Predictor copy of the pending HI16 stack.
	logic [31:0] hi_addr_stack [PEND_DEPTH];
	logic [31:0] hi_word_stack [PEND_DEPTH];
	int          hi_fill = 0;

	int send_idle_pct  = 0;
	int recv_stall_pct = 0;
	int relocs_done    = 0;
	int results_seen   = 0;
	int hi_drained     = 0;
	int full_refusals  = 0;
	int errors         = 0;
	int hold_left      = 0;
	logic hold_done    = 1'b0;
	int quiet_cycles   = 0;

	mips_rel_relocation_patcher u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

	// Free-running clock, 12 ns period.
	always begin
		clk = 1'b0;
		#6;
		clk = 1'b1;
		#6;
	end

	function automatic logic [31:0] sign_ext_half(input logic [15:0] half);
		return {{16{half[15]}}, half};
	endfunction

	task automatic expect_beat(input logic [31:0] addr, input logic [31:0] data,
			input logic we, input logic [2:0] st, input logic fin);
		out_item_t beat;
		beat.write_address = addr;
		beat.write_data    = data;
		beat.write_enable  = we;
		beat.status        = st;
		beat.last          = fin;
		expected_writes.push_back(beat);
	endtask

	// Works out the write beats that one relocation causes and updates the HI16 stack.
	task automatic apply_relocation(input in_item_t it);
		logic [31:0] addr;
		logic [31:0] word;
		logic [31:0] sym;
		logic [31:0] sum;
		logic [31:0] lo;
		logic [31:0] seg;
		logic [31:0] stacked;
		addr = it.target_address;
		word = it.current_word;
		sym  = it.symbol_value;
		case (it.opcode)
			OP_NONE: begin
				expect_beat(addr, word, 1'b0, ST_OK, 1'b1);
			end
			OP_ABS16: begin
				sum = sym + sign_ext_half(word[15:0]);
				if (sum[31:16] != 16'h0)
					expect_beat(addr, word, 1'b0, ST_OVERFLOW, 1'b1);
				else
					expect_beat(addr, {word[31:16], sum[15:0]}, 1'b1, ST_OK, 1'b1);
			end
			OP_ABS32: begin
				sum = sym + word;
				expect_beat(addr, sum, sum != word, ST_OK, 1'b1);
			end
			OP_JUMP26: begin
				seg = {4'h0, word[25:0], 2'b00};
				if (it.is_section_symbol) begin
					sum = (sym + ((addr & SEG_MASK) | seg)) >> 2;
				end else begin
					if (seg[27])
						seg = seg | SEG_MASK;
					sum = (seg + sym) >> 2;
				end
				expect_beat(addr, {word[31:26], sum[25:0]}, 1'b1, ST_OK, 1'b1);
			end
			OP_HI16: begin
				if (hi_fill >= PEND_DEPTH) begin
					expect_beat(addr, word, 1'b0, ST_FULL, 1'b1);
					full_refusals++;
				end else begin
					hi_addr_stack[hi_fill] = addr;
					hi_word_stack[hi_fill] = word;
					hi_fill++;
					expect_beat(addr, word, 1'b0, ST_OK, 1'b1);
				end
			end
			OP_LO16: begin
				if (sym == 32'h0) begin
					expect_beat(addr, word, 1'b0, ST_ZERO_SYM, 1'b1);
				end else begin
					// Own word first, then every pending HI16 from the top down.
					lo  = sign_ext_half(word[15:0]);
					sum = lo + sym;
					expect_beat(addr, {word[31:16], sum[15:0]}, 1'b1, ST_OK, hi_fill == 0);
					while (hi_fill != 0) begin
						hi_fill--;
						stacked = hi_word_stack[hi_fill];
						sum = {stacked[15:0], 16'h0} + lo + sym;
						sum = sum - sign_ext_half(sum[15:0]);
						expect_beat(hi_addr_stack[hi_fill], {stacked[31:16], sum[31:16]},
							1'b1, ST_OK, hi_fill == 0);
						hi_drained++;
					end
				end
			end
			OP_PC16: begin
				sum = sym + (sign_ext_half(word[15:0]) << 2) - addr;
				sum = {{2{sum[31]}}, sum[31:2]};
				lo  = sum + 32'h8000;
				if (lo >= 32'h1_0000)
					expect_beat(addr, word, 1'b0, ST_OVERFLOW, 1'b1);
				else
					expect_beat(addr, {word[31:16], sum[15:0]}, 1'b1, ST_OK, 1'b1);
			end
			default: begin
				expect_beat(addr, word, 1'b0, ST_UNSUP, 1'b1);
			end
		endcase
	endtask

	task automatic log_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		errors++;
		$display("mismatch at result %0d: %s got %h, expected %h",
			results_seen, what, got, want);
	endtask

	// Compares one accepted write beat with the oldest outstanding expectation.
	task automatic check_result(input out_item_t got);
		out_item_t want;
		results_seen++;
		if (expected_writes.size() == 0) begin
			log_mismatch("beat with nothing outstanding, address", got.write_address, 32'h0);
			return;
		end
		want = expected_writes.pop_front();
		if (got.write_address !== want.write_address)
			log_mismatch("write_address", got.write_address, want.write_address);
		if (got.write_data !== want.write_data)
			log_mismatch("write_data", got.write_data, want.write_data);
		if (got.write_enable !== want.write_enable)
			log_mismatch("write_enable", 32'(got.write_enable), 32'(want.write_enable));
		if (got.status !== want.status)
			log_mismatch("status", 32'(got.status), 32'(want.status));
		if (got.last !== want.last)
			log_mismatch("last", 32'(got.last), 32'(want.last));
	endtask

	// Driver: predicts on every accepted beat and offers the next relocation.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_valid <= 1'b0;
			req       <= '0;
		end else begin
			if (req_valid && !req_stall) begin
				apply_relocation(req);
				relocs_done++;
			end
			if (!req_valid || !req_stall) begin
				if (relocs_todo.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					req_valid <= 1'b1;
					req       <= relocs_todo.pop_front();
				end else begin
					req_valid <= 1'b0;
				end
			end
		end
	end

	// Monitor: checks accepted results and drives the stall, with one long hold-off.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_stall <= 1'b0;
			hold_left <= 0;
			hold_done <= 1'b0;
		end else begin
			if (rsp_valid && !rsp_stall)
				check_result(rsp);
			if (hold_left != 0) begin
				hold_left <= hold_left - 1;
				rsp_stall <= 1'b1;
			end else if (!hold_done && results_seen >= HOLD_AFTER) begin
				hold_left <= HOLD_CYCLES - 1;
				hold_done <= 1'b1;
				rsp_stall <= 1'b1;
			end else begin
				rsp_stall <= ($urandom_range(99) < recv_stall_pct);
			end
		end
	end

	// Watchdog: ends the run when no beat moves on either side for too long.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
				quiet_cycles <= 0;
			end else if (quiet_cycles >= QUIET_LIMIT) begin
				$display("watchdog: no beat moved for %0d cycles", quiet_cycles);
				$display("status: fail");
				$finish;
			end else begin
				quiet_cycles <= quiet_cycles + 1;
			end
		end
	end

	task automatic queue_reloc(input logic [2:0] op, input logic [31:0] addr,
			input logic [31:0] word, input logic [31:0] sym, input logic sect);
		in_item_t it;
		it.opcode            = op;
		it.target_address    = addr;
		it.current_word      = word;
		it.symbol_value      = sym;
		it.is_section_symbol = sect;
		relocs_todo.push_back(it);
	endtask

	// One relocation of random type, with values steered toward the in-range cases when shaped is set.
	task automatic queue_single(input logic shaped);
		logic [2:0]  op;
		logic [31:0] addr;
		logic [31:0] word;
		logic [31:0] sym;
		op   = 3'($urandom_range(7));
		addr = $urandom;
		word = $urandom;
		sym  = $urandom;
		if (shaped) begin
			case (op)
				OP_ABS16:
					if ($urandom_range(1)) sym = $urandom_range(32'h1_ffff);
				OP_ABS32:
					if ($urandom_range(4) == 0) sym = 32'h0;
				OP_PC16:
					if ($urandom_range(1)) sym = addr + $urandom_range(32'h7_ffff) - 32'h4_0000;
				OP_LO16:
					if ($urandom_range(4) == 0) sym = 32'h0;
				default: ;
			endcase
		end
		queue_reloc(op, addr, word, sym, 1'($urandom_range(1)));
	endtask

	// A run of HI16 entries closed by a LO16, sometimes with one random relocation in between.
	task automatic queue_hi_lo_group();
		int depth;
		depth = ($urandom_range(9) == 0) ? $urandom_range(12, 5) : $urandom_range(4);
		for (int i = 0; i < depth; i++)
			queue_reloc(OP_HI16, $urandom, $urandom, $urandom, 1'($urandom_range(1)));
		if ($urandom_range(3) == 0)
			queue_single(1'b1);
		queue_reloc(OP_LO16, $urandom, $urandom,
			($urandom_range(9) == 0) ? 32'h0 : $urandom, 1'($urandom_range(1)));
	endtask

	task automatic queue_random_relocs(input int count);
		int goal;
		int pick;
		goal = relocs_todo.size() + count;
		while (relocs_todo.size() < goal) begin
			pick = $urandom_range(99);
			if (pick < 45)
				queue_hi_lo_group();
			else if (pick < 85)
				queue_single(1'b1);
			else
				queue_single(1'b0);
		end
	endtask

	// Fills the stack past its depth, then drains it with one LO16.
	task automatic queue_stack_overrun();
		for (int i = 0; i < PEND_DEPTH + 3; i++)
			queue_reloc(OP_HI16, $urandom, $urandom, $urandom, 1'($urandom_range(1)));
		queue_reloc(OP_LO16, $urandom, $urandom, $urandom | 32'h1, 1'b0);
	endtask

	task automatic queue_directed();
		queue_reloc(OP_NONE, 32'h0, 32'h0, 32'h0, 1'b0);
		queue_reloc(OP_NONE, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 1'b1);
		queue_reloc(OP_ABS16, 32'h0000_1000, 32'h1234_8000, 32'h0000_9000, 1'b0);
		queue_reloc(OP_ABS16, 32'h0000_1004, 32'h0000_7fff, 32'h0000_8001, 1'b0);
		queue_reloc(OP_ABS32, 32'h0000_2000, 32'hdead_beef, 32'h0, 1'b0);
		queue_reloc(OP_ABS32, 32'h0000_2004, 32'h0000_0001, 32'hffff_ffff, 1'b1);
		queue_reloc(OP_JUMP26, 32'ha000_0000, 32'h0c00_0100, 32'h0000_1000, 1'b1);
		queue_reloc(OP_JUMP26, 32'h8000_0010, 32'h0bff_ffff, 32'h0040_0000, 1'b0);
		queue_reloc(OP_JUMP26, 32'h8000_0014, 32'h0c00_0040, 32'h0040_0000, 1'b0);
		// A LO16 with nothing pending writes only its own word.
		queue_reloc(OP_LO16, 32'h0000_3000, 32'h2421_0010, 32'h0000_0010, 1'b0);
		queue_reloc(OP_HI16, 32'h0000_0100, 32'h3c01_0001, 32'h0, 1'b0);
		queue_reloc(OP_HI16, 32'h0000_0104, 32'h3c02_ffff, 32'h0, 1'b0);
		// A zero symbol must leave both pending entries in place.
		queue_reloc(OP_LO16, 32'h0000_0108, 32'h2421_0004, 32'h0, 1'b0);
		queue_reloc(OP_LO16, 32'h0000_010c, 32'h2421_8000, 32'h0001_7fff, 1'b0);
		queue_reloc(OP_PC16, 32'h0000_1000, 32'h1000_0010, 32'h0000_2000, 1'b0);
		queue_reloc(OP_PC16, 32'h0001_0000, 32'h1000_0000, 32'h0005_0000, 1'b0);
		queue_reloc(OP_PC16, 32'h0010_0000, 32'h1000_0000, 32'h000b_fffc, 1'b0);
		// PC16 at both ends of the signed 16-bit range.
		queue_reloc(OP_PC16, 32'h0000_4000, 32'h1000_0000, 32'h0002_3ffc, 1'b0);
		queue_reloc(OP_PC16, 32'h0004_0000, 32'h1000_0000, 32'h0002_0000, 1'b0);
		queue_reloc(OP_UNSUP, 32'h0000_5000, 32'h0123_4567, 32'h89ab_cdef, 1'b1);
		queue_reloc(OP_HI16, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 1'b1);
		queue_reloc(OP_LO16, 32'h0000_0000, 32'h0000_0000, 32'hffff_ffff, 1'b1);
	endtask

	task automatic wait_drained();
		while (relocs_todo.size() != 0 || req_valid || expected_writes.size() != 0)
			@(negedge clk);
	endtask

	// Stimulus in three idling phases, then the verdict.
	initial begin
		send_idle_pct  = 23;
		recv_stall_pct = 60;
		queue_directed();
		queue_stack_overrun();
		queue_random_relocs(80);
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		wait_drained();

		send_idle_pct  = 60;
		recv_stall_pct = 23;
		queue_random_relocs(90);
		wait_drained();

		send_idle_pct  = 0;
		recv_stall_pct = 0;
		queue_random_relocs(90);
		wait_drained();

		repeat (40) @(posedge clk);
		$display("run covered %0d relocations and %0d result beats over three stall phases",
			relocs_done, results_seen);
		$display("pending HI16 entries drained: %0d, pushes refused on a full stack: %0d",
			hi_drained, full_refusals);
		if (errors == 0) begin
			$display("status: pass");
		end else begin
			$display("%0d mismatches", errors);
			$display("status: fail");
		end
		$finish;
	end

endmodule
